FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; included by the files that hold assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in run encoder checker");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed in run encoder checker");

`endif

FILE: design/gwtre_pkg.sv
// Shared types, register codes and constants of the gray threshold run encoder.
// No dependencies; used by every module of the block.
package gwtre_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int GRAY_W = 8;
    localparam int SIZE_W = 13;
    localparam int POS_W  = 12;
    localparam int IDX_W  = 23;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 64;

    // register indexes, byte address = 4 * index
    localparam logic [1:0] REG_MIN_GRAY     = 2'd0;
    localparam logic [1:0] REG_MAX_GRAY     = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [GRAY_W-1:0] MIN_GRAY_RST     = 8'd0;
    localparam logic [GRAY_W-1:0] MAX_GRAY_RST     = 8'd255;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [GRAY_W-1:0] min_gray;
        logic [GRAY_W-1:0] max_gray;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] run_index;
        logic [POS_W-1:0] run_end;
        logic [POS_W-1:0] run_row;
        logic [POS_W-1:0] run_start;
    } t_run;

endpackage

FILE: design/gwtre_cfg_regs.sv
// APB configuration registers: gray band and image size.
// Depends on gwtre_pkg.
module gwtre_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gwtre_pkg::ADDR_W-1:0]     paddr,
    input  logic [gwtre_pkg::DATA_W-1:0]     pwdata,
    output logic [gwtre_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    output gwtre_pkg::t_cfg                  o_cfg
);

    gwtre_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gray     <= gwtre_pkg::MIN_GRAY_RST;
            r_cfg.max_gray     <= gwtre_pkg::MAX_GRAY_RST;
            r_cfg.frame_width  <= gwtre_pkg::FRAME_WIDTH_RST;
            r_cfg.frame_height <= gwtre_pkg::FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                gwtre_pkg::REG_MIN_GRAY:     r_cfg.min_gray     <= pwdata[7:0];
                gwtre_pkg::REG_MAX_GRAY:     r_cfg.max_gray     <= pwdata[7:0];
                gwtre_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[12:0];
                gwtre_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gwtre_pkg::REG_MIN_GRAY:     prdata = {24'd0, r_cfg.min_gray};
            gwtre_pkg::REG_MAX_GRAY:     prdata = {24'd0, r_cfg.max_gray};
            gwtre_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, r_cfg.frame_width};
            gwtre_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, r_cfg.frame_height};
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/gwtre_run_core.sv
// Thresholding, position counters and run tracking for one pixel per cycle.
// Depends on gwtre_pkg.
module gwtre_run_core #(
    parameter int MAX_WIDTH  = gwtre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gwtre_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gwtre_pkg::t_cfg                   i_cfg,
    input  logic                              i_accept,
    input  logic [gwtre_pkg::GRAY_W-1:0]      i_pixel,
    output logic                              o_push,
    output gwtre_pkg::t_run                   o_run
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LW  = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;
    localparam int LH  = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13;
    localparam int EW  = (CW > gwtre_pkg::POS_W) ? CW : gwtre_pkg::POS_W;
    localparam int ERW = (RW > gwtre_pkg::POS_W) ? RW : gwtre_pkg::POS_W;

    logic [CW-1:0]               r_col, n_col;
    logic [RW-1:0]               r_row, n_row;
    logic                        r_open, n_open;
    logic [CW-1:0]               r_open_start, n_open_start;
    logic [gwtre_pkg::IDX_W-1:0] r_runs, n_runs;

    logic [LW-1:0] w_raw, w_eff;
    logic [LH-1:0] h_raw, h_eff;
    logic          fg, last_col, last_row, emit;
    logic [CW-1:0] start_col, end_col;
    logic [EW-1:0] start_ext, end_ext;
    logic [ERW-1:0] row_ext;

    always_comb begin
        w_raw = LW'(i_cfg.frame_width);
        h_raw = LH'(i_cfg.frame_height);
        if (w_raw == '0)
            w_eff = LW'(1);
        else if (w_raw > LW'(MAX_WIDTH))
            w_eff = LW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw == '0)
            h_eff = LH'(1);
        else if (h_raw > LH'(MAX_HEIGHT))
            h_eff = LH'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // counter at or past the last position counts as the last position
    assign last_col = (LW'(r_col) + LW'(1)) >= w_eff;
    assign last_row = (LH'(r_row) + LH'(1)) >= h_eff;
    assign fg       = (i_pixel >= i_cfg.min_gray) && (i_pixel <= i_cfg.max_gray);
    assign emit     = fg ? last_col : r_open;

    assign start_col = (fg && !r_open) ? r_col : r_open_start;
    // a run closed by background ended on the previous column
    assign end_col   = fg ? r_col : (r_col - CW'(1));

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_open       = r_open;
        n_open_start = r_open_start;
        n_runs       = r_runs;
        if (i_accept) begin
            n_open_start = start_col;
            n_open       = fg && !last_col;
            if (emit)
                n_runs = r_runs + gwtre_pkg::IDX_W'(1);
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_runs = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_open       <= 1'b0;
            r_open_start <= '0;
            r_runs       <= '0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_open       <= n_open;
            r_open_start <= n_open_start;
            r_runs       <= n_runs;
        end
    end

    assign start_ext = EW'(start_col);
    assign end_ext   = EW'(end_col);
    assign row_ext   = ERW'(r_row);

    assign o_push          = i_accept && emit;
    assign o_run.run_start = start_ext[gwtre_pkg::POS_W-1:0];
    assign o_run.run_row   = row_ext[gwtre_pkg::POS_W-1:0];
    assign o_run.run_end   = end_ext[gwtre_pkg::POS_W-1:0];
    assign o_run.run_index = r_runs;

endmodule

FILE: design/gwtre_out_skid.sv
// Result register with a skid entry, so input keeps flowing while a run waits.
// Depends on gwtre_pkg.
module gwtre_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gwtre_pkg::t_run  i_run,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output gwtre_pkg::t_run  o_run
);

    gwtre_pkg::t_run r_main, n_main;
    gwtre_pkg::t_run r_skid, n_skid;
    logic            r_main_v, n_main_v;
    logic            r_skid_v, n_skid_v;
    logic            pop;

    assign pop = r_main_v && i_pop_ready;

    always_comb begin
        n_main   = r_main;
        n_skid   = r_skid;
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        if (pop && r_skid_v) begin
            // upstream is held off while the skid entry is full
            n_main   = r_skid;
            n_skid_v = 1'b0;
        end else if (pop || !r_main_v) begin
            n_main   = i_run;
            n_main_v = i_push;
        end else if (i_push) begin
            n_skid   = i_run;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_run   = r_main;

endmodule

FILE: design/gray_window_threshold_run_encoder_top.sv
// Gray window threshold run encoder: pixel items in, runs out on a stream.
// Each closed run is registered, in the skid entry if the result register still holds one.
// Throughput: one pixel item per cycle while o_s_axis_tready is high.
// A stalled output holds one run and a second in the skid entry before input stalls.
// Reset (synchronous, active low) clears counters, run state and output valids and
// loads the register reset values.
module gray_window_threshold_run_encoder_top #(
    parameter int MAX_WIDTH  = gwtre_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gwtre_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] pixel
    input  logic [gwtre_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [11:0] run_start, [23:12] run_row, [35:24] run_end, [58:36] run_index, rest zero
    output logic [gwtre_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gwtre_pkg::ADDR_W-1:0]        paddr,
    input  logic [gwtre_pkg::DATA_W-1:0]        pwdata,
    output logic [gwtre_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    gwtre_pkg::t_cfg cfg;
    gwtre_pkg::t_run core_run;
    gwtre_pkg::t_run out_run;
    logic            core_push;
    logic            in_accept;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    gwtre_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gwtre_run_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_pixel  (i_s_axis_tdata[7:0]),
        .o_push   (core_push),
        .o_run    (core_run)
    );

    gwtre_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (core_push),
        .i_run       (core_run),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_run       (out_run)
    );

    assign o_m_axis_tdata = {5'd0, out_run.run_index, out_run.run_end,
                             out_run.run_row, out_run.run_start};

endmodule

FILE: design/gwtre_checker.sv
// Port-level checks on the run encoder's streams, bound to the top level.
// Depends on gwtre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gwtre_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [gwtre_pkg::TDATA_OUT_W-1:0]  o_m_axis_tdata
);

    // a waiting run holds its data
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))

    // reset empties both result entries
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))

    // input only stalls while a run is waiting at the output
    `ASSERT_CLK(a_stall_has_run, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid)

    // the skid entry fills only behind a stalled output
    `ASSERT_CLK(a_fill_on_stall, i_clk, i_rst_n, $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))

endmodule

bind gray_window_threshold_run_encoder_top gwtre_checker u_gwtre_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: verif/tb_gray_window_threshold_run_encoder_top.sv
// Self-checking testbench for the gray window threshold run encoder.
// Drives pixel items and APB register writes into the top level and checks every emitted run
// against a cycle-free model of the encoder. Depends on gwtre_pkg and the top-level RTL.
module tb_gray_window_threshold_run_encoder_top;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_mode;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_s_axis_tvalid = 1'b0;
    logic                                 o_s_axis_tready;
    logic [gwtre_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata = '0;
    logic                                 o_m_axis_tvalid;
    logic                                 i_m_axis_tready = 1'b0;
    logic [gwtre_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [gwtre_pkg::ADDR_W-1:0]         paddr = '0;
    logic [gwtre_pkg::DATA_W-1:0]         pwdata = '0;
    logic [gwtre_pkg::DATA_W-1:0]         prdata;
    logic                                 pready;

    gray_window_threshold_run_encoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 i_clk = ~i_clk;

    // encoder model state and register shadow
    gwtre_pkg::t_cfg             cfg_shadow = '{gwtre_pkg::MIN_GRAY_RST,
                                                gwtre_pkg::MAX_GRAY_RST,
                                                gwtre_pkg::FRAME_WIDTH_RST,
                                                gwtre_pkg::FRAME_HEIGHT_RST};
    logic [gwtre_pkg::POS_W-1:0] cur_col = '0;
    logic [gwtre_pkg::POS_W-1:0] cur_row = '0;
    logic                        run_is_open = 1'b0;
    logic [gwtre_pkg::POS_W-1:0] run_first_col = '0;
    logic [gwtre_pkg::IDX_W-1:0] next_run_index = '0;
    gwtre_pkg::t_run             expected_runs[$];

    int       mismatch_count = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       hold_request = 0;
    int       hold_left = 0;
    int       rx_tick = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic int clamp_size(input int v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic void close_run(input logic [gwtre_pkg::POS_W-1:0] last_col_of_run);
        gwtre_pkg::t_run r;
        r.run_start = run_first_col;
        r.run_row   = cur_row;
        r.run_end   = last_col_of_run;
        r.run_index = next_run_index;
        expected_runs.push_back(r);
        next_run_index = next_run_index + 1'b1;
    endfunction

    // one accepted pixel: update the model and queue any run it closes
    function automatic void track_pixel(input logic [gwtre_pkg::GRAY_W-1:0] pix);
        int   w;
        int   h;
        logic fg;
        logic at_row_end;
        w = clamp_size(cfg_shadow.frame_width, gwtre_pkg::MAX_WIDTH_DEF);
        h = clamp_size(cfg_shadow.frame_height, gwtre_pkg::MAX_HEIGHT_DEF);
        fg = (pix >= cfg_shadow.min_gray) && (pix <= cfg_shadow.max_gray);
        at_row_end = int'(cur_col) >= w - 1;
        if (fg) begin
            if (!run_is_open) begin
                run_first_col = cur_col;
                run_is_open = 1'b1;
            end
            if (at_row_end) begin
                close_run(cur_col);
                run_is_open = 1'b0;
            end
        end else if (run_is_open) begin
            close_run(cur_col - 1'b1);
            run_is_open = 1'b0;
        end
        if (at_row_end) begin
            cur_col = '0;
            run_is_open = 1'b0;
            if (int'(cur_row) >= h - 1) begin
                cur_row = '0;
                next_run_index = '0;
            end else begin
                cur_row = cur_row + 1'b1;
            end
        end else begin
            cur_col = cur_col + 1'b1;
        end
    endfunction

    // run checker
    always @(posedge i_clk) begin : check_runs
        gwtre_pkg::t_run got;
        gwtre_pkg::t_run want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[58:0];
            if (expected_runs.size() == 0) begin
                report_mismatch("run with none pending, run_index", -1, got.run_index);
            end else begin
                want = expected_runs.pop_front();
                if (got.run_start !== want.run_start)
                    report_mismatch("run_start", want.run_start, got.run_start);
                if (got.run_row !== want.run_row)
                    report_mismatch("run_row", want.run_row, got.run_row);
                if (got.run_end !== want.run_end)
                    report_mismatch("run_end", want.run_end, got.run_end);
                if (got.run_index !== want.run_index)
                    report_mismatch("run_index", want.run_index, got.run_index);
                if (o_m_axis_tdata[63:59] !== 5'd0)
                    report_mismatch("tdata padding", 0, o_m_axis_tdata[63:59]);
            end
        end
    end

    // output stall pattern, with an optional long hold-off counted here
    always @(posedge i_clk) begin : drive_ready
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_axis_tready <= 1'b1;
                RX_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: i_m_axis_tready <= (rx_tick % 7 != 3) && (rx_tick % 5 != 0);
                default:    i_m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [gwtre_pkg::DATA_W-1:0] val);
        logic [gwtre_pkg::DATA_W-1:0] rd;
        logic [gwtre_pkg::DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            gwtre_pkg::REG_MIN_GRAY:
                cfg_shadow.min_gray = val[gwtre_pkg::GRAY_W-1:0];
            gwtre_pkg::REG_MAX_GRAY:
                cfg_shadow.max_gray = val[gwtre_pkg::GRAY_W-1:0];
            gwtre_pkg::REG_FRAME_WIDTH:
                cfg_shadow.frame_width = val[gwtre_pkg::SIZE_W-1:0];
            default:
                cfg_shadow.frame_height = val[gwtre_pkg::SIZE_W-1:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        // read back
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == gwtre_pkg::REG_MIN_GRAY || idx == gwtre_pkg::REG_MAX_GRAY)
            want = {24'd0, val[gwtre_pkg::GRAY_W-1:0]};
        else
            want = {19'd0, val[gwtre_pkg::SIZE_W-1:0]};
        if (rd !== want)
            report_mismatch("register readback", want, rd);
    endtask

    task automatic set_window(input int lo, input int hi, input int w, input int h);
        write_reg(gwtre_pkg::REG_MIN_GRAY, lo);
        write_reg(gwtre_pkg::REG_MAX_GRAY, hi);
        write_reg(gwtre_pkg::REG_FRAME_WIDTH, w);
        write_reg(gwtre_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task automatic send_pixel(input logic [gwtre_pkg::GRAY_W-1:0] pix);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_pixel(pix);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 8'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // sender stops and waits until every pending run has been delivered
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // biased toward the window edges and inside the window
    function automatic logic [gwtre_pkg::GRAY_W-1:0] pick_pixel(input int band_pct);
        logic [gwtre_pkg::GRAY_W-1:0] lo;
        logic [gwtre_pkg::GRAY_W-1:0] hi;
        lo = cfg_shadow.min_gray;
        hi = cfg_shadow.max_gray;
        case ($urandom_range(0, 9))
            0: return lo - 1'b1;
            1: return hi + 1'b1;
            2: return lo;
            3: return hi;
            default: begin
                if ($urandom_range(0, 99) < band_pct && lo <= hi)
                    return 8'($urandom_range(lo, hi));
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_pixel_stream(input int count, input int band_pct, input bit gaps);
        int burst;
        burst = $urandom_range(1, 16);
        repeat (count) begin
            send_pixel(pick_pixel(band_pct));
            burst--;
            if (burst == 0) begin
                if (gaps)
                    idle_sender($urandom_range(0, 4));
                burst = $urandom_range(1, 16);
            end
        end
        wait_drain();
    endtask

    // register values after reset: full window, 640 pixel rows
    task automatic test_reset_size();
        rx_mode = RX_RANDOM;
        send_pixel_stream(200, 90, 1'b1);
    endtask

    task automatic test_directed();
        rx_mode = RX_PATTERN;
        // row 1 is the last row of the frame here, so the frame wraps after it
        set_window(10, 200, 4, 2);
        send_pixel(8'd9);
        send_pixel(8'd10);
        send_pixel(8'd200);
        send_pixel(8'd201);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd10);
        send_pixel(8'd10);
        wait_drain();
        // single-value window
        set_window(128, 128, 4, 2);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd129);
        send_pixel(8'd128);
        wait_drain();
        // empty window
        set_window(200, 100, 4, 2);
        send_pixel(8'd100);
        send_pixel(8'd150);
        send_pixel(8'd200);
        send_pixel(8'd0);
        wait_drain();
        // zero sizes act as one: every pixel is a whole frame
        set_window(0, 255, 0, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd77);
        wait_drain();
    endtask

    // shrink the image while in the middle of a row and of a frame
    task automatic test_size_shrink();
        rx_mode = RX_RANDOM;
        set_window(50, 180, 10, 5);
        send_pixel_stream(37, 70, 1'b1);
        write_reg(gwtre_pkg::REG_FRAME_WIDTH, 3);
        write_reg(gwtre_pkg::REG_FRAME_HEIGHT, 2);
        send_pixel_stream(20, 70, 1'b1);
    endtask

    // long output hold-off with the sender running flat out
    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        set_window(100, 150, 6, 4);
        hold_request = 300;
        for (int i = 0; i < 100; i++)
            send_pixel(i % 2 ? 8'(8'd100 + $urandom_range(0, 50)) : 8'($urandom_range(0, 99)));
        wait_drain();
    endtask

    // oversize registers clamp to the largest image, so rows and frames run on
    task automatic test_size_extremes();
        rx_mode = RX_ALWAYS;
        set_window(20, 235, 8191, 2);
        send_pixel_stream(30, 80, 1'b0);
        set_window(30, 220, 1, 8191);
        send_pixel_stream(30, 70, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [gwtre_pkg::DATA_W-1:0] junk;
        int lo;
        int hi;
        int w;
        int h;
        int swap;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0: lo = 0;
                1: lo = 255;
                default: lo = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 3))
                0: hi = 255;
                1: hi = 0;
                default: hi = $urandom_range(0, 255);
            endcase
            if (lo > hi && $urandom_range(0, 4) != 0) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 1;
                2: w = 8191;
                default: w = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 7))
                0: h = 0;
                1: h = 1;
                2: h = 8191;
                default: h = $urandom_range(2, 8);
            endcase
            // unused upper bits of the write data must be ignored
            junk = $urandom_range(0, 1) ? $urandom : 32'd0;
            if ($urandom_range(0, 9) < 7)
                write_reg(gwtre_pkg::REG_MIN_GRAY, lo | (junk & 32'hFFFF_FF00));
            if ($urandom_range(0, 9) < 7)
                write_reg(gwtre_pkg::REG_MAX_GRAY, hi | (junk & 32'hFFFF_FF00));
            if ($urandom_range(0, 9) < 7)
                write_reg(gwtre_pkg::REG_FRAME_WIDTH, w | (junk & 32'hFFFF_E000));
            if ($urandom_range(0, 9) < 7)
                write_reg(gwtre_pkg::REG_FRAME_HEIGHT, h | (junk & 32'hFFFF_E000));
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            send_pixel_stream(75, $urandom_range(30, 90), $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin : main
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_size();
        test_directed();
        test_size_shrink();
        test_backpressure();
        test_size_extremes();
        test_random_phases();
        for (int n = 0; n < 100000 && expected_runs.size() != 0; n++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (expected_runs.size() != 0)
            report_mismatch("runs never delivered", expected_runs.size(), 0);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
